// ----- rtl/jsc_pkg.sv -----
package jsc_pkg;

    // Loop constants
    localparam int FULL_SCALE  = 2048;
    localparam int SAMPLE_BITS = 12;

    // Field widths
    localparam int X_W    = 12;
    localparam int DZ_W   = 11;
    localparam int T_W    = 32;
    localparam int D_W    = 16;
    localparam int COIL_W = 4;
    localparam int PH_W   = 3;
    localparam int IDX_W  = 3;
    localparam int DEN_W  = 13;
    localparam int PROD_W = X_W + D_W;

    localparam logic [X_W-1:0] X_MASK = X_W'((1 << SAMPLE_BITS) - 1);

    // Register map of the configuration port
    typedef enum logic [IDX_W-1:0] {
        REG_CENTRE   = 3'd0,
        REG_DEADZONE = 3'd1,
        REG_DEBOUNCE = 3'd2,
        REG_SLOW     = 3'd3,
        REG_FAST     = 3'd4,
        REG_HALF     = 3'd5
    } reg_idx_t;

    // Eight-phase half-step coil table
    function automatic logic [COIL_W-1:0] half_coils(input logic [PH_W-1:0] ph);
        logic [COIL_W-1:0] c;
        case (ph)
            3'd0:    c = 4'h8;
            3'd1:    c = 4'hC;
            3'd2:    c = 4'h4;
            3'd3:    c = 4'h6;
            3'd4:    c = 4'h2;
            3'd5:    c = 4'h3;
            3'd6:    c = 4'h1;
            default: c = 4'h9;
        endcase
        return c;
    endfunction

    // Four-phase full-step coil table
    function automatic logic [COIL_W-1:0] full_coils(input logic [1:0] ph);
        logic [COIL_W-1:0] c;
        case (ph)
            2'd0:    c = 4'h9;
            2'd1:    c = 4'hC;
            2'd2:    c = 4'h6;
            default: c = 4'h3;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/jsc_muldiv.sv -----
module jsc_muldiv (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [jsc_pkg::X_W-1:0]    mul_a,
    input  logic [jsc_pkg::D_W-1:0]    mul_b,
    input  logic [jsc_pkg::DEN_W-1:0]  den,
    output logic                       done,
    output logic [jsc_pkg::PROD_W-1:0] quot
);
    import jsc_pkg::*;

    localparam int CNT_W = $clog2(PROD_W + 1);

    typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} md_state_t;

    md_state_t          state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [X_W-1:0]     a_reg;
    logic [D_W-1:0]     b_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [PROD_W-1:0]  acc_reg;
    logic [DEN_W-1:0]   rem_reg;
    logic               done_reg;

    logic [PROD_W-1:0]  mul_next;
    logic [DEN_W:0]     trial;
    logic [DEN_W:0]     diff;
    logic               fits;

    // Shift-add multiply, one multiplier bit per cycle, MSB first
    assign mul_next = {acc_reg[PROD_W-2:0], 1'b0}
                    + (a_reg[X_W-1] ? PROD_W'(b_reg) : '0);

    // Restoring divide, one quotient bit per cycle
    assign trial = {rem_reg, acc_reg[PROD_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                MD_IDLE: begin
                    if (start) begin
                        a_reg     <= mul_a;
                        b_reg     <= mul_b;
                        den_reg   <= den;
                        acc_reg   <= '0;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= MD_MUL;
                    end
                end
                MD_MUL: begin
                    acc_reg <= mul_next;
                    a_reg   <= {a_reg[X_W-2:0], 1'b0};
                    if (cnt_reg == CNT_W'(X_W - 1)) begin
                        cnt_reg   <= '0;
                        state_reg <= MD_DIV;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                MD_DIV: begin
                    rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                    acc_reg <= {acc_reg[PROD_W-2:0], fits};
                    if (cnt_reg == CNT_W'(PROD_W - 1)) begin
                        cnt_reg   <= '0;
                        done_reg  <= 1'b1;
                        state_reg <= MD_IDLE;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                default: state_reg <= MD_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign quot = acc_reg;

endmodule

// ----- rtl/joystick_stepper_control.sv -----
// Flow: an input transaction is taken only in ST_IDLE; its result is registered
// in the pending-result registers and moved to the output register from ST_DONE
// once that is free. With interpolation, ST_CALC first waits for the bit-serial
// multiply/divide unit. No new input is taken until the last result moves on.
// Reset (aresetn low, synchronous): registers take their defaults, motor enabled,
// phase 0, button released, no result pending.
module joystick_stepper_control (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [jsc_pkg::X_W-1:0]     s_x_sample,
    input  logic                        s_button_pressed,
    input  logic [jsc_pkg::T_W-1:0]     s_now_ms,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [jsc_pkg::COIL_W-1:0]  m_coil_pattern,
    output logic                        m_stepping,
    output logic [jsc_pkg::D_W-1:0]     m_step_delay_us,
    output logic                        m_motor_enabled,
    input  logic                        cfg_we,
    input  logic [jsc_pkg::IDX_W-1:0]   cfg_index,
    input  logic [jsc_pkg::D_W-1:0]     cfg_wdata
);
    import jsc_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_DONE} state_t;

    // Configuration
    logic [X_W-1:0]    centre_reg;
    logic [DZ_W-1:0]   deadzone_reg;
    logic [D_W-1:0]    debounce_reg;
    logic [D_W-1:0]    slow_reg;
    logic [D_W-1:0]    fast_reg;
    logic              half_reg;

    // Loop state
    state_t            state_reg;
    logic [PH_W-1:0]   phase_reg;
    logic              enable_reg;
    logic              last_raw_reg;
    logic              stable_reg;
    logic [T_W-1:0]    change_time_reg;

    // Pending result
    logic [COIL_W-1:0] res_coil_reg;
    logic              res_step_reg;
    logic [D_W-1:0]    res_delay_reg;
    logic              res_en_reg;

    // Output register
    logic              m_valid_reg;
    logic [COIL_W-1:0] m_coil_reg;
    logic              m_step_reg;
    logic [D_W-1:0]    m_delay_reg;
    logic              m_en_reg;

    logic              accept;
    logic [X_W-1:0]    x_m;
    logic              neg;
    logic [X_W-1:0]    mag;
    logic [T_W-1:0]    ct_eff;
    logic [T_W-1:0]    elapsed;
    logic              take;
    logic              en_eff;
    logic              step_go;
    logic [PH_W-1:0]   ph_mask;
    logic [PH_W-1:0]   phase_next;
    logic [COIL_W-1:0] coils;
    logic [DEN_W:0]    den_full;
    logic              den_pos;
    logic              need_div;
    logic [D_W-1:0]    quick_delay;
    logic [D_W-1:0]    span;
    logic [X_W-1:0]    mul_a;
    logic              md_done;
    logic [PROD_W-1:0] quot;
    logic [D_W-1:0]    div_delay;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Deviation from centre
    assign x_m = s_x_sample & X_MASK;
    assign neg = x_m < centre_reg;
    assign mag = neg ? (centre_reg - x_m) : (x_m - centre_reg);

    // Debounce and enable toggle
    assign ct_eff  = (s_button_pressed != last_raw_reg) ? s_now_ms : change_time_reg;
    assign elapsed = s_now_ms - ct_eff;
    assign take    = (elapsed > T_W'(debounce_reg)) && (s_button_pressed != stable_reg);
    assign en_eff  = enable_reg ^ (take && s_button_pressed);
    assign step_go = (mag > X_W'(deadzone_reg)) && en_eff;

    // Phase advance and coil lookup
    assign ph_mask    = half_reg ? 3'd7 : 3'd3;
    assign phase_next = neg ? ((phase_reg + 3'd1) & ph_mask)
                            : ((phase_reg + ph_mask) & ph_mask);
    assign coils      = half_reg ? half_coils(phase_next) : full_coils(phase_next[1:0]);

    // Delay: interpolate only when slow exceeds fast and deadzone is below FULL_SCALE
    assign den_full    = (DEN_W+1)'(FULL_SCALE) - (DEN_W+1)'(deadzone_reg);
    assign den_pos     = !den_full[DEN_W] && (den_full != '0);
    assign need_div    = den_pos && (slow_reg > fast_reg);
    assign quick_delay = (den_pos || (fast_reg > slow_reg)) ? slow_reg : fast_reg;
    assign span        = slow_reg - fast_reg;
    assign mul_a       = mag - X_W'(deadzone_reg);
    assign div_delay   = (quot > PROD_W'(span)) ? fast_reg : (slow_reg - quot[D_W-1:0]);

    jsc_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept && step_go && need_div),
        .mul_a   (mul_a),
        .mul_b   (span),
        .den     (den_full[DEN_W-1:0]),
        .done    (md_done),
        .quot    (quot)
    );

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            centre_reg   <= 12'd2945;
            deadzone_reg <= 11'd200;
            debounce_reg <= 16'd50;
            slow_reg     <= 16'd4000;
            fast_reg     <= 16'd1200;
            half_reg     <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_CENTRE:   centre_reg   <= cfg_wdata[X_W-1:0];
                REG_DEADZONE: deadzone_reg <= cfg_wdata[DZ_W-1:0];
                REG_DEBOUNCE: debounce_reg <= cfg_wdata;
                REG_SLOW:     slow_reg     <= cfg_wdata;
                REG_FAST:     fast_reg     <= cfg_wdata;
                REG_HALF:     half_reg     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Control pass sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            phase_reg       <= '0;
            enable_reg      <= 1'b1;
            last_raw_reg    <= 1'b0;
            stable_reg      <= 1'b0;
            change_time_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            // Drop the result once taken, unless a new one is loaded
            if (m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        change_time_reg <= ct_eff;
                        last_raw_reg    <= s_button_pressed;
                        if (take) begin
                            stable_reg <= s_button_pressed;
                        end
                        enable_reg    <= en_eff;
                        res_en_reg    <= en_eff;
                        res_step_reg  <= step_go;
                        res_coil_reg  <= step_go ? coils : '0;
                        res_delay_reg <= step_go ? quick_delay : '0;
                        if (step_go) begin
                            phase_reg <= phase_next;
                        end
                        state_reg <= (step_go && need_div) ? ST_CALC : ST_DONE;
                    end
                end
                ST_CALC: begin
                    if (md_done) begin
                        res_delay_reg <= div_delay;
                        state_reg     <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // Hand over once the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_coil_reg  <= res_coil_reg;
                        m_step_reg  <= res_step_reg;
                        m_delay_reg <= res_delay_reg;
                        m_en_reg    <= res_en_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_coil_pattern  = m_coil_reg;
    assign m_stepping      = m_step_reg;
    assign m_step_delay_us = m_delay_reg;
    assign m_motor_enabled = m_en_reg;

endmodule
